// ===== rtl/stun_message_deframer_macros.svh =====
// Assertion macros for the STUN message deframer.
`ifndef STUN_MESSAGE_DEFRAMER_MACROS_SVH
`define STUN_MESSAGE_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stmd check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stmd check failed");

`endif

// ===== rtl/stmd_pkg.sv =====
// Shared types and constants of the STUN message deframer.
package stmd_pkg;

  localparam logic [16:0] HDR_BYTES = 17'd20;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [15:0] CR_LIMIT  = 16'h7FFF;

  localparam logic [15:0] INTEGRITY_RST   = 16'h0008;
  localparam logic [15:0] FINGERPRINT_RST = 16'h8028;

  localparam logic [1:0] REG_INTEGRITY   = 2'd0;
  localparam logic [1:0] REG_FINGERPRINT = 2'd1;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ATTR   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_SIZE4    = 3'd2;
  localparam logic [2:0] ST_LENF4    = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_OVERRUN  = 3'd5;

  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  // room for one word in flight and one being accepted, two records each
  localparam logic [QAW:0] QHI_LEVEL = (QAW+1)'(QDEPTH - 4);

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [1:0]  msg_class;
    logic [15:0] type_code;
    logic [15:0] length_value;
    logic [31:0] hdr_cookie;
    logic [31:0] txn_id_high;
    logic [63:0] txn_id_low;
    logic [15:0] value_offset;
    logic        ignored;
    logic        comp_required;
    logic [2:0]  status;
    logic        run_last;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

// ===== rtl/stmd_parse.sv =====
// Input register, framing state and record decode of the STUN deframer.
module stmd_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic [7:0]    in_data_byte,
  input  logic          in_packet_end,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output stmd_pkg::push_t push
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        end_r;

  logic [15:0] integrity_r;
  logic [15:0] fingerprint_r;

  logic [16:0] cnt_r, cnt_nxt;
  logic [63:0] hs0_r, hs0_nxt;
  logic [31:0] hs1_r, hs1_nxt;
  logic [63:0] hs2_r, hs2_nxt;
  logic [31:0] ah_r, ah_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [16:0] skip_r, skip_nxt;
  logic        seen_r, seen_nxt;
  logic        fe_r, fe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_accept;
    end
    if (in_accept) begin
      byte_r <= in_data_byte;
      end_r  <= in_packet_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integrity_r   <= stmd_pkg::INTEGRITY_RST;
      fingerprint_r <= stmd_pkg::FINGERPRINT_RST;
    end else if (cfg_we) begin
      if (cfg_index == stmd_pkg::REG_INTEGRITY) begin
        integrity_r <= cfg_data;
      end
      if (cfg_index == stmd_pkg::REG_FINGERPRINT) begin
        fingerprint_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      hs0_r   <= '0;
      hs1_r   <= '0;
      hs2_r   <= '0;
      ah_r    <= '0;
      phase_r <= '0;
      skip_r  <= '0;
      seen_r  <= 1'b0;
      fe_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      hs0_r   <= hs0_nxt;
      hs1_r   <= hs1_nxt;
      hs2_r   <= hs2_nxt;
      ah_r    <= ah_nxt;
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      seen_r  <= seen_nxt;
      fe_r    <= fe_nxt;
    end
  end

  logic [15:0]  t;
  logic [15:0]  atyp;
  logic [15:0]  alen;
  logic [17:0]  off_full;
  logic [16:0]  len_pad;
  logic [16:0]  cnt_less_hdr;
  logic         ign;
  logic         have_rec;
  logic [2:0]   st;
  stmd_pkg::rec_t rec_a;
  stmd_pkg::rec_t rec_s;

  always_comb begin
    cnt_nxt   = cnt_r;
    hs0_nxt   = hs0_r;
    hs1_nxt   = hs1_r;
    hs2_nxt   = hs2_r;
    ah_nxt    = ah_r;
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    seen_nxt  = seen_r;
    fe_nxt    = fe_r;
    have_rec  = 1'b0;
    rec_a     = '0;
    rec_s     = '0;
    push      = '0;
    t         = hs0_r[63:48];
    ah_nxt    = ah_r;
    atyp      = '0;
    alen      = '0;
    ign       = 1'b0;
    off_full  = {1'b0, cnt_r} + 18'd1;
    len_pad   = '0;
    st        = stmd_pkg::ST_OK;
    cnt_less_hdr = '0;

    if (valid_r) begin
      if (cnt_r != stmd_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + 17'd1;
      end else begin
        fe_nxt = 1'b1;
      end

      if (cnt_r < stmd_pkg::HDR_BYTES) begin
        if (cnt_r < 17'd8) begin
          hs0_nxt = {hs0_r[55:0], byte_r};
        end else if (cnt_r < 17'd12) begin
          hs1_nxt = {hs1_r[23:0], byte_r};
        end else begin
          hs2_nxt = {hs2_r[55:0], byte_r};
        end
        if (cnt_r == stmd_pkg::HDR_BYTES - 17'd1) begin
          have_rec           = 1'b1;
          rec_a.record_kind  = stmd_pkg::KIND_HEADER;
          rec_a.msg_class    = {t[8], t[4]};
          rec_a.type_code    = {4'd0, t[13:9], t[7:5], t[3:0]};
          rec_a.length_value = hs0_r[47:32];
          rec_a.hdr_cookie   = hs0_r[31:0];
          rec_a.txn_id_high  = hs1_r;
          rec_a.txn_id_low   = hs2_nxt;
        end
      end else if (skip_r != 17'd0) begin
        skip_nxt = skip_r - 17'd1;
      end else begin
        ah_nxt = {ah_r[23:0], byte_r};
        if (phase_r == 2'd3) begin
          atyp      = ah_nxt[31:16];
          alen      = ah_nxt[15:0];
          ign       = seen_r && (atyp != fingerprint_r);
          phase_nxt = 2'd0;
          if (off_full[17:16] != 2'd0) begin
            fe_nxt = 1'b1;
          end
          if (!ign && atyp == integrity_r) begin
            seen_nxt = 1'b1;
          end
          len_pad  = {1'b0, alen} + 17'd3;
          skip_nxt = {len_pad[16:2], 2'b00};
          have_rec            = 1'b1;
          rec_a.record_kind   = stmd_pkg::KIND_ATTR;
          rec_a.type_code     = atyp;
          rec_a.length_value  = alen;
          rec_a.value_offset  = (off_full[17:16] != 2'd0) ? 16'hFFFF : off_full[15:0];
          rec_a.ignored       = ign;
          rec_a.comp_required = !ign && (atyp <= stmd_pkg::CR_LIMIT);
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end

      cnt_less_hdr = cnt_nxt - stmd_pkg::HDR_BYTES;
      priority if (cnt_nxt < stmd_pkg::HDR_BYTES) begin
        st = stmd_pkg::ST_SHORT;
      end else if (cnt_nxt[1:0] != 2'd0) begin
        st = stmd_pkg::ST_SIZE4;
      end else if (hs0_nxt[33:32] != 2'd0) begin
        st = stmd_pkg::ST_LENF4;
      end else if (cnt_less_hdr != {1'b0, hs0_nxt[47:32]}) begin
        st = stmd_pkg::ST_MISMATCH;
      end else if (skip_nxt != 17'd0 || phase_nxt != 2'd0 || fe_nxt) begin
        st = stmd_pkg::ST_OVERRUN;
      end else begin
        st = stmd_pkg::ST_OK;
      end
      rec_s.record_kind = stmd_pkg::KIND_STATUS;
      rec_s.status      = st;
      rec_s.run_last    = 1'b1;
      rec_a.run_last    = !end_r;

      if (have_rec) begin
        push.rec0  = rec_a;
        push.rec1  = rec_s;
        push.count = end_r ? 2'd2 : 2'd1;
      end else begin
        push.rec0  = rec_s;
        push.count = end_r ? 2'd1 : 2'd0;
      end

      if (end_r) begin
        cnt_nxt   = '0;
        hs0_nxt   = '0;
        hs1_nxt   = '0;
        hs2_nxt   = '0;
        ah_nxt    = '0;
        phase_nxt = '0;
        skip_nxt  = '0;
        seen_nxt  = 1'b0;
        fe_nxt    = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/stmd_outq.sv =====
// STUN deframer result queue: up to two records in a cycle, one out per pop.
module stmd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  stmd_pkg::push_t     push,
  input  logic                pop,
  output logic                out_valid,
  output stmd_pkg::rec_t      head,
  output logic                level_hi
);

  stmd_pkg::rec_t               q_r [stmd_pkg::QDEPTH];
  logic [stmd_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [stmd_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [stmd_pkg::QAW:0]       cnt_r, cnt_nxt;
  logic [stmd_pkg::QAW-1:0]     wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + stmd_pkg::QAW'(push.count);
    rd_ptr_nxt = rd_ptr_r + stmd_pkg::QAW'(pop);
    cnt_nxt    = cnt_r + (stmd_pkg::QAW+1)'(push.count) - (stmd_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[wr_ptr_r] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      q_r[wr_ptr_p1] <= push.rec1;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign level_hi  = (cnt_r > stmd_pkg::QHI_LEVEL);

endmodule

// ===== rtl/stun_message_deframer.sv =====
// STUN message deframer top level.
// Usage:
//   Input channel in_*: one packet byte per word, network order, with
//   in_packet_end on the final byte. A word moves when in_valid is high
//   and in_stall is low.
//   Result channel out_*: header, attribute and end-status records, one
//   per word. out_run_last marks the last record a byte produced.
//   Config channel cfg_*: cfg_index 0 sets the MESSAGE-INTEGRITY type,
//   1 the FINGERPRINT type; other indexes are dropped. cfg_ready is
//   always high; write only while the block is idle.
// Path: a byte is taken into the input register, then decoded, and its
//   records are written into the 8-entry result queue, which offers
//   them from its head.
// Throughput: one byte per cycle. A byte yields at most two records; the
//   queue drains one per cycle if out_stall is low; in_stall rises once
//   over four records wait, so output rate sets sustained input rate.
// Reset: rst_n low clears the framing state and the queue and
//   restores the register defaults (8 and 0x8028).
// Receiver stall: out_stall holds the head record; the queue absorbs the
//   records in flight, then in_stall is raised.
module stun_message_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [1:0]  out_msg_class,
  output logic [15:0] out_type_code,
  output logic [15:0] out_length_value,
  output logic [31:0] out_hdr_cookie,
  output logic [31:0] out_txn_id_high,
  output logic [63:0] out_txn_id_low,
  output logic [15:0] out_value_offset,
  output logic        out_ignored,
  output logic        out_comp_required,
  output logic [2:0]  out_status,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  stmd_pkg::push_t push;
  stmd_pkg::rec_t  head;
  logic            level_hi;
  logic            in_accept;
  logic            pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = level_hi;
  assign in_accept = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  stmd_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_data_byte  (in_data_byte),
    .in_packet_end (in_packet_end),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push)
  );

  stmd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .out_valid (out_valid),
    .head      (head),
    .level_hi  (level_hi)
  );

  assign out_record_kind   = head.record_kind;
  assign out_msg_class     = head.msg_class;
  assign out_type_code     = head.type_code;
  assign out_length_value  = head.length_value;
  assign out_hdr_cookie    = head.hdr_cookie;
  assign out_txn_id_high   = head.txn_id_high;
  assign out_txn_id_low    = head.txn_id_low;
  assign out_value_offset  = head.value_offset;
  assign out_ignored       = head.ignored;
  assign out_comp_required = head.comp_required;
  assign out_status        = head.status;
  assign out_run_last      = head.run_last;

endmodule

// ===== rtl/stmd_checker.sv =====
// Port-level checks of the STUN message deframer, bound to the top level.
`include "stun_message_deframer_macros.svh"

module stmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_record_kind,
  input logic [15:0] out_value_offset,
  input logic        out_ignored,
  input logic        out_comp_required,
  input logic [2:0]  out_status,
  input logic        out_run_last
);

  `STMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `STMD_ASSERT_NOW(a_status_last, out_valid && out_record_kind == stmd_pkg::KIND_STATUS,
    out_run_last)
  `STMD_ASSERT_NOW(a_header_clean, out_valid && out_record_kind == stmd_pkg::KIND_HEADER,
    out_value_offset == 16'd0 && !out_ignored && out_status == stmd_pkg::ST_OK)
  `STMD_ASSERT_NOW(a_attr_flags, out_valid && out_record_kind == stmd_pkg::KIND_ATTR,
    !(out_ignored && out_comp_required) && out_status == stmd_pkg::ST_OK)

endmodule

bind stun_message_deframer stmd_checker u_stmd_checker (.*);
